@@ rtl/tlst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlst_pkg
// Shared types and constants for the two-level sector translator.
// ----------------------------------------------------------------------------
package tlst_pkg;

	localparam int TABLE_DEPTH_DEF  = 4096;
	localparam int SECTOR_BYTES_DEF = 512;

	localparam int CLUSTER_W = 5;
	localparam int TABLE_W   = 4;
	localparam int CFG_W     = 5;
	localparam int INDEX_W   = 12;
	localparam int VALUE_W   = 64;
	localparam int SECTOR_W  = 55;
	localparam int SHIFT_W   = 6;

	localparam logic [CLUSTER_W-1:0] CLUSTER_LOW   = 5'd12;
	localparam logic [CLUSTER_W-1:0] CLUSTER_HIGH  = 5'd26;
	localparam logic [CLUSTER_W-1:0] CLUSTER_RESET = 5'd16;
	localparam logic [TABLE_W-1:0]   TABLE_LOW     = 4'd9;
	localparam logic [TABLE_W-1:0]   TABLE_HIGH    = 4'd12;
	localparam logic [TABLE_W-1:0]   TABLE_RESET   = 4'd12;

	// Width of the offset within a cluster and of a masked second-level index.
	localparam int WITHIN_W = 26;
	localparam int L2_W     = 12;

	typedef enum logic [0:0] {
		REG_CLUSTER_BITS = 1'b0,
		REG_TABLE_BITS   = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_WRITE_L1  = 2'd0,
		OP_WRITE_L2  = 2'd1,
		OP_SET_TAG   = 2'd2,
		OP_TRANSLATE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE       = 2'd0,
		ST_TRANSLATED = 2'd1,
		ST_RANGE      = 2'd2,
		ST_LOAD       = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		FSM_IDLE    = 1'b0,
		FSM_RESOLVE = 1'b1
	} fsm_t;

endpackage

@@ rtl/tlst_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlst_ram
// Single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module tlst_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/two_level_sector_translator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_sector_translator
// Maps a sector number to an image file byte offset through a first-level
// table and one cached second-level table.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_ready; every request gives exactly one result
// on out_valid/out_ready. Table writes and the tag set load the output register
// as they are taken, and their result appears there on the next cycle. A
// translation reads both tables at once in the cycle it is taken; the data
// comes back from the registered RAM reads in the next cycle, when the tag
// compare and the add are resolved; the resolve step then loads the output
// register, and no further request is taken while a translation is in it.
// The output register is a full stage: a new request is taken while a result
// waits, as long as the result is taken in the same cycle; if the receiver
// stalls, a translation holds in its resolve step and no further request is
// taken. Reset clears the loaded tag and its valid flag and restores
// cluster_bits to 16 and table_bits to 12; table contents are undefined until
// written. Configuration is written through cfg_we.
// ----------------------------------------------------------------------------
module two_level_sector_translator #(
	parameter int TABLE_DEPTH  = tlst_pkg::TABLE_DEPTH_DEF,
	parameter int SECTOR_BYTES = tlst_pkg::SECTOR_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             cfg_we,
	input  logic [0:0]                       cfg_index,
	input  logic [tlst_pkg::CFG_W-1:0]       cfg_data,

	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       operation,
	input  logic [tlst_pkg::INDEX_W-1:0]     entry_index,
	input  logic [tlst_pkg::VALUE_W-1:0]     entry_value,
	input  logic [tlst_pkg::SECTOR_W-1:0]    sector_number,

	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       status,
	output logic [tlst_pkg::VALUE_W-1:0]     file_offset,
	output logic [tlst_pkg::VALUE_W-1:0]     table_address
);

	localparam int AW          = $clog2(TABLE_DEPTH);
	localparam int SECTOR_SH   = $clog2(SECTOR_BYTES);

	// Configuration registers.
	logic [tlst_pkg::CLUSTER_W-1:0] cluster_bits_q;
	logic [tlst_pkg::TABLE_W-1:0]   table_bits_q;
	logic [tlst_pkg::CLUSTER_W-1:0] cluster_clamped;
	logic [tlst_pkg::TABLE_W-1:0]   table_clamped;

	// Tag of the loaded second-level table.
	logic [tlst_pkg::VALUE_W-1:0]   loaded_tag_q;
	logic                           tag_valid_q;

	tlst_pkg::fsm_t                 state_q, state_d;

	// Address decode of a translation.
	logic [tlst_pkg::VALUE_W-1:0]   byte_off;
	logic [tlst_pkg::SHIFT_W-1:0]   l1_shift;
	logic [tlst_pkg::VALUE_W-1:0]   l1_full;
	logic [tlst_pkg::L2_W-1:0]      l2_mask;
	logic [tlst_pkg::L2_W-1:0]      l2_idx;
	logic [tlst_pkg::VALUE_W-1:0]   within_mask;
	logic                           oor;

	logic                           oor_s1;
	logic [tlst_pkg::WITHIN_W-1:0]  within_s1;

	// Memory ports.
	logic                           accept;
	logic                           rd_en;
	logic                           l1_we;
	logic                           l2_we;
	logic [AW-1:0]                  widx;
	logic [tlst_pkg::VALUE_W-1:0]   l1_rdata;
	logic [tlst_pkg::VALUE_W-1:0]   l2_rdata;

	// Output register.
	logic                           out_valid_q;
	logic [1:0]                     status_q;
	logic [tlst_pkg::VALUE_W-1:0]   file_offset_q;
	logic [tlst_pkg::VALUE_W-1:0]   table_address_q;
	logic                           out_load;
	logic [1:0]                     status_d;
	logic [tlst_pkg::VALUE_W-1:0]   file_offset_d;
	logic [tlst_pkg::VALUE_W-1:0]   table_address_d;

	// Out-of-range values saturate; table_bits clamps cfg_data[3:0] only.
	always_comb begin
		if (cfg_data < tlst_pkg::CLUSTER_LOW) begin
			cluster_clamped = tlst_pkg::CLUSTER_LOW;
		end else if (cfg_data > tlst_pkg::CLUSTER_HIGH) begin
			cluster_clamped = tlst_pkg::CLUSTER_HIGH;
		end else begin
			cluster_clamped = cfg_data;
		end
		if (cfg_data[tlst_pkg::TABLE_W-1:0] < tlst_pkg::TABLE_LOW) begin
			table_clamped = tlst_pkg::TABLE_LOW;
		end else if (cfg_data[tlst_pkg::TABLE_W-1:0] > tlst_pkg::TABLE_HIGH) begin
			table_clamped = tlst_pkg::TABLE_HIGH;
		end else begin
			table_clamped = cfg_data[tlst_pkg::TABLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_bits_q <= tlst_pkg::CLUSTER_RESET;
			table_bits_q   <= tlst_pkg::TABLE_RESET;
		end else if (cfg_we) begin
			unique case (tlst_pkg::cfg_reg_t'(cfg_index))
				tlst_pkg::REG_CLUSTER_BITS: cluster_bits_q <= cluster_clamped;
				tlst_pkg::REG_TABLE_BITS:   table_bits_q   <= table_clamped;
			endcase
		end
	end

	// Index arithmetic on the byte offset.
	always_comb begin
		byte_off    = tlst_pkg::VALUE_W'({9'd0, sector_number} << SECTOR_SH);
		l1_shift    = tlst_pkg::SHIFT_W'(cluster_bits_q) + tlst_pkg::SHIFT_W'(table_bits_q);
		l1_full     = byte_off >> l1_shift;
		oor         = (l1_full >> table_bits_q) != '0;
		l2_mask     = tlst_pkg::L2_W'((13'd1 << table_bits_q) - 13'd1);
		l2_idx      = tlst_pkg::L2_W'(byte_off >> cluster_bits_q) & l2_mask;
		within_mask = (64'd1 << cluster_bits_q) - 64'd1;
	end

	assign accept = in_valid && in_ready;
	assign rd_en  = accept && (operation == tlst_pkg::OP_TRANSLATE);
	assign l1_we  = accept && (operation == tlst_pkg::OP_WRITE_L1);
	assign l2_we  = accept && (operation == tlst_pkg::OP_WRITE_L2);
	assign widx   = AW'(entry_index);

	tlst_ram #(
		.WIDTH (tlst_pkg::VALUE_W),
		.DEPTH (TABLE_DEPTH)
	) u_l1_ram (
		.clk   (clk),
		.we    (l1_we),
		.waddr (widx),
		.wdata (entry_value),
		.re    (rd_en),
		.raddr (AW'(l1_full)),
		.rdata (l1_rdata)
	);

	tlst_ram #(
		.WIDTH (tlst_pkg::VALUE_W),
		.DEPTH (TABLE_DEPTH)
	) u_l2_ram (
		.clk   (clk),
		.we    (l2_we),
		.waddr (widx),
		.wdata (entry_value),
		.re    (rd_en),
		.raddr (AW'(l2_idx)),
		.rdata (l2_rdata)
	);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			oor_s1    <= oor;
			within_s1 <= tlst_pkg::WITHIN_W'(byte_off & within_mask);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_tag_q <= '0;
			tag_valid_q  <= 1'b0;
		end else if (accept && operation == tlst_pkg::OP_SET_TAG) begin
			loaded_tag_q <= entry_value;
			tag_valid_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlst_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		in_ready        = 1'b0;
		out_load        = 1'b0;
		status_d        = tlst_pkg::ST_DONE;
		file_offset_d   = '0;
		table_address_d = '0;
		unique case (state_q)
			tlst_pkg::FSM_IDLE: begin
				in_ready = !out_valid_q || out_ready;
				if (in_valid && in_ready) begin
					if (operation == tlst_pkg::OP_TRANSLATE) begin
						state_d = tlst_pkg::FSM_RESOLVE;
					end else begin
						out_load = 1'b1;
					end
				end
			end
			tlst_pkg::FSM_RESOLVE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = tlst_pkg::FSM_IDLE;
				end
				priority if (oor_s1) begin
					status_d = tlst_pkg::ST_RANGE;
				end else if (!tag_valid_q || l1_rdata != loaded_tag_q) begin
					status_d        = tlst_pkg::ST_LOAD;
					table_address_d = l1_rdata;
				end else begin
					status_d      = tlst_pkg::ST_TRANSLATED;
					file_offset_d = l2_rdata + tlst_pkg::VALUE_W'(within_s1);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q        <= status_d;
			file_offset_q   <= file_offset_d;
			table_address_q <= table_address_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign file_offset   = file_offset_q;
	assign table_address = table_address_q;

endmodule

@@ tb/tb_two_level_sector_translator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_level_sector_translator
// Self-checking bench for the two-level sector translator. A behavioural
// model of both tables, the loaded tag and the two geometry registers
// predicts one answer per request. A monitor compares each answer the block
// returns, in order, against those predictions. Stimulus covers directed
// corner cases, register saturation, host-like load sequences with random
// content, stray requests, random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module tb_two_level_sector_translator;

	localparam int VALUE_W          = tlst_pkg::VALUE_W;
	localparam int INDEX_W          = tlst_pkg::INDEX_W;
	localparam int SECTOR_W         = tlst_pkg::SECTOR_W;
	localparam int CFG_W            = tlst_pkg::CFG_W;
	localparam int TABLE_DEPTH_DEF  = tlst_pkg::TABLE_DEPTH_DEF;
	localparam int SECTOR_BYTES_DEF = tlst_pkg::SECTOR_BYTES_DEF;

	typedef struct packed {
		tlst_pkg::status_t   status;
		logic [VALUE_W-1:0]  file_offset;
		logic [VALUE_W-1:0]  table_address;
	} sector_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [0:0]           cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           operation;
	logic [INDEX_W-1:0]   entry_index;
	logic [VALUE_W-1:0]   entry_value;
	logic [SECTOR_W-1:0]  sector_number;
	logic                 out_valid;
	logic                 out_ready;
	logic [1:0]           status;
	logic [VALUE_W-1:0]   file_offset;
	logic [VALUE_W-1:0]   table_address;

	// Model of the block's state.
	logic [VALUE_W-1:0]   l1_table [TABLE_DEPTH_DEF];
	logic [VALUE_W-1:0]   l2_table [TABLE_DEPTH_DEF];
	bit                   l1_written [TABLE_DEPTH_DEF];
	bit                   l2_written [TABLE_DEPTH_DEF];
	logic [VALUE_W-1:0]   loaded_tag = '0;
	bit                   tag_loaded = 1'b0;
	int unsigned          cluster_bits_q = tlst_pkg::CLUSTER_RESET;
	int unsigned          table_bits_q = tlst_pkg::TABLE_RESET;

	sector_result_t       expected_results [$];
	tlst_pkg::status_t    last_status;
	logic [VALUE_W-1:0]   last_table_address;
	logic [VALUE_W-1:0]   table_pool [4];
	int                   mismatches = 0;
	int                   accepted_requests = 0;
	int unsigned          sender_idle_pct = 7;
	int unsigned          receiver_idle_pct = 54;
	int                   hold_request = 0;
	int                   hold_left = 0;

	two_level_sector_translator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.entry_index   (entry_index),
		.entry_value   (entry_value),
		.sector_number (sector_number),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.file_offset   (file_offset),
		.table_address (table_address)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [VALUE_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic int unsigned entry_count();
		return 1 << table_bits_q;
	endfunction

	function automatic int unsigned saturate(int unsigned v, int unsigned lo, int unsigned hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	function automatic logic [SECTOR_W-1:0] random_sector();
		return SECTOR_W'(rand64() >> $urandom_range(63, 9));
	endfunction

	function automatic logic [VALUE_W-1:0] random_cluster_off();
		return rand64() & ((64'd1 << cluster_bits_q) - 64'd1)
			& ~64'(SECTOR_BYTES_DEF - 1);
	endfunction

	function automatic logic [VALUE_W-1:0] pick_table_address();
		return ($urandom_range(3) != 0) ? table_pool[$urandom_range(3)] : rand64();
	endfunction

	function automatic logic [SECTOR_W-1:0] sector_at(int unsigned l1_idx, int unsigned l2_idx,
			logic [VALUE_W-1:0] cluster_off);
		logic [VALUE_W-1:0] byte_off;
		byte_off = (64'(l1_idx) << (cluster_bits_q + table_bits_q))
			| (64'(l2_idx) << cluster_bits_q) | cluster_off;
		return SECTOR_W'(byte_off / SECTOR_BYTES_DEF);
	endfunction

	function automatic void split_sector(input logic [SECTOR_W-1:0] sector,
			output logic [VALUE_W-1:0] byte_off, output logic [VALUE_W-1:0] l1_idx,
			output logic [VALUE_W-1:0] l2_idx);
		byte_off = 64'(sector) * 64'(SECTOR_BYTES_DEF);
		l1_idx   = byte_off >> (cluster_bits_q + table_bits_q);
		l2_idx   = (byte_off >> cluster_bits_q) & 64'(entry_count() - 1);
	endfunction

	function automatic sector_result_t lookup_sector(logic [SECTOR_W-1:0] sector);
		logic [VALUE_W-1:0] byte_off, l1_idx, l2_idx, tag;
		sector_result_t res;
		split_sector(sector, byte_off, l1_idx, l2_idx);
		res = '{status: tlst_pkg::ST_DONE, file_offset: '0, table_address: '0};
		if (l1_idx >= 64'(entry_count())) begin
			res.status = tlst_pkg::ST_RANGE;
		end else begin
			tag = l1_table[l1_idx[INDEX_W-1:0]];
			if (!tag_loaded || tag != loaded_tag) begin
				res.status        = tlst_pkg::ST_LOAD;
				res.table_address = tag;
			end else begin
				res.status      = tlst_pkg::ST_TRANSLATED;
				res.file_offset = l2_table[l2_idx[INDEX_W-1:0]]
					+ (byte_off & ((64'd1 << cluster_bits_q) - 64'd1));
			end
		end
		return res;
	endfunction

	function automatic void record_request(tlst_pkg::op_t op, logic [INDEX_W-1:0] idx,
			logic [VALUE_W-1:0] value, logic [SECTOR_W-1:0] sector);
		sector_result_t want;
		want = '{status: tlst_pkg::ST_DONE, file_offset: '0, table_address: '0};
		case (op)
			tlst_pkg::OP_WRITE_L1: begin
				l1_table[idx]   = value;
				l1_written[idx] = 1'b1;
			end
			tlst_pkg::OP_WRITE_L2: begin
				l2_table[idx]   = value;
				l2_written[idx] = 1'b1;
			end
			tlst_pkg::OP_SET_TAG: begin
				loaded_tag = value;
				tag_loaded = 1'b1;
			end
			default: begin
				want               = lookup_sector(sector);
				last_status        = want.status;
				last_table_address = want.table_address;
			end
		endcase
		expected_results.push_back(want);
		accepted_requests++;
	endfunction

	task automatic send_request(tlst_pkg::op_t op, logic [INDEX_W-1:0] idx,
			logic [VALUE_W-1:0] value, logic [SECTOR_W-1:0] sector);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= op;
		entry_index   <= idx;
		entry_value   <= value;
		sector_number <= sector;
		do @(posedge clk); while (!in_ready);
		record_request(op, idx, value, sector);
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic reconfigure(logic [CFG_W-1:0] cluster_raw, logic [CFG_W-1:0] table_raw);
		wait_for_drain();
		cfg_we    <= 1'b1;
		cfg_index <= tlst_pkg::REG_CLUSTER_BITS;
		cfg_data  <= cluster_raw;
		@(posedge clk);
		cfg_index <= tlst_pkg::REG_TABLE_BITS;
		cfg_data  <= table_raw;
		@(posedge clk);
		cfg_we <= 1'b0;
		cluster_bits_q = saturate(cluster_raw, tlst_pkg::CLUSTER_LOW, tlst_pkg::CLUSTER_HIGH);
		table_bits_q   = saturate(table_raw & 5'hF, tlst_pkg::TABLE_LOW, tlst_pkg::TABLE_HIGH);
	endtask

	task automatic translate_sector(logic [SECTOR_W-1:0] sector);
		logic [VALUE_W-1:0] byte_off, l1_idx, l2_idx;
		split_sector(sector, byte_off, l1_idx, l2_idx);
		// An in-range lookup may only read entries that have been written.
		if (l1_idx < 64'(entry_count())) begin
			if (!l1_written[l1_idx[INDEX_W-1:0]])
				send_request(tlst_pkg::OP_WRITE_L1, l1_idx[INDEX_W-1:0],
					pick_table_address(), random_sector());
			if (tag_loaded && l1_table[l1_idx[INDEX_W-1:0]] == loaded_tag
					&& !l2_written[l2_idx[INDEX_W-1:0]])
				send_request(tlst_pkg::OP_WRITE_L2, l2_idx[INDEX_W-1:0], rand64(),
					random_sector());
		end
		send_request(tlst_pkg::OP_TRANSLATE, INDEX_W'($urandom), rand64(), sector);
	endtask

	task automatic host_session();
		int unsigned entries, l1_idx, l2_base, burst, k;
		logic [VALUE_W-1:0] wanted_table;
		entries = entry_count();
		// About half the sessions stay among the first four first-level entries so that tags recur.
		l1_idx  = ($urandom_range(1) != 0) ? $urandom_range(3) : $urandom_range(entries - 1);
		l2_base = $urandom_range(entries - 1);
		translate_sector(sector_at(l1_idx, l2_base, random_cluster_off()));
		if (last_status == tlst_pkg::ST_LOAD) begin
			wanted_table = last_table_address;
			for (k = 0; k < 4; k++)
				send_request(tlst_pkg::OP_WRITE_L2, INDEX_W'((l2_base + k) % entries),
					rand64(), random_sector());
			// Now and then the host loads the wrong table.
			send_request(tlst_pkg::OP_SET_TAG, INDEX_W'($urandom),
				($urandom_range(9) == 0) ? rand64() : wanted_table, random_sector());
		end
		burst = $urandom_range(6, 1);
		for (k = 0; k < burst; k++)
			translate_sector(sector_at(l1_idx, (l2_base + $urandom_range(3)) % entries,
				random_cluster_off()));
	endtask

	task automatic stray_request();
		case ($urandom_range(4))
			0: send_request(tlst_pkg::OP_WRITE_L1, INDEX_W'($urandom), pick_table_address(),
				random_sector());
			1: send_request(tlst_pkg::OP_WRITE_L2, INDEX_W'($urandom), rand64(),
				random_sector());
			2: send_request(tlst_pkg::OP_SET_TAG, INDEX_W'($urandom), pick_table_address(),
				random_sector());
			default: translate_sector(random_sector());
		endcase
	endtask

	task automatic probe_table_bounds();
		int unsigned last_entry;
		last_entry = entry_count() - 1;
		translate_sector(sector_at(last_entry, last_entry,
			(64'd1 << cluster_bits_q) - 64'(SECTOR_BYTES_DEF)));
		translate_sector(sector_at(0, 0, 64'd0));
		// First sector past the end of the first-level table.
		translate_sector(SECTOR_W'((64'd1 << (cluster_bits_q + 2 * table_bits_q))
			/ SECTOR_BYTES_DEF));
	endtask

	task automatic test_directed_lookup();
		// With no table loaded, even a zero entry that equals the zero tag asks for a load.
		send_request(tlst_pkg::OP_WRITE_L1, 12'd0, 64'd0, '1);
		send_request(tlst_pkg::OP_TRANSLATE, '1, '1, 55'd0);
		send_request(tlst_pkg::OP_WRITE_L2, 12'd0, '1, 55'd0);
		send_request(tlst_pkg::OP_SET_TAG, 12'd0, 64'd0, 55'd0);
		// Largest offset within the first cluster; the sum wraps past the top.
		send_request(tlst_pkg::OP_TRANSLATE, 12'd0, 64'd0, 55'h7F);
		send_request(tlst_pkg::OP_TRANSLATE, 12'd0, 64'd0, 55'd0);
		send_request(tlst_pkg::OP_WRITE_L1, 12'hFFF, '1, 55'd0);
		send_request(tlst_pkg::OP_TRANSLATE, 12'd0, 64'd0, 55'h7FFF_FFFF);
		send_request(tlst_pkg::OP_TRANSLATE, 12'd0, 64'd0, 55'h8000_0000);
		send_request(tlst_pkg::OP_TRANSLATE, 12'd0, 64'd0, '1);
		send_request(tlst_pkg::OP_SET_TAG, 12'd0, '1, 55'd0);
		send_request(tlst_pkg::OP_WRITE_L2, 12'hFFF, 64'h8000_0000_0000_0000, 55'd0);
		send_request(tlst_pkg::OP_TRANSLATE, 12'd0, 64'd0, 55'h7FFF_FFFF);
		send_request(tlst_pkg::OP_TRANSLATE, 12'd0, 64'd0, 55'd0);
	endtask

	task automatic test_register_limits();
		logic [CFG_W-1:0] cluster_settings [7] = '{5'd12, 5'd26, 5'd0, 5'd31, 5'd11, 5'd27, 5'd16};
		logic [CFG_W-1:0] table_settings [7]   = '{5'd9, 5'd12, 5'd16, 5'd31, 5'd8, 5'd13, 5'd12};
		foreach (cluster_settings[s]) begin
			reconfigure(cluster_settings[s], table_settings[s]);
			probe_table_bounds();
			repeat (3) host_session();
		end
	endtask

	task automatic test_random_traffic(int count);
		int stop_at, next_reconfig;
		stop_at       = accepted_requests + count;
		next_reconfig = accepted_requests + 150;
		while (accepted_requests < stop_at) begin
			if (accepted_requests >= next_reconfig) begin
				reconfigure(CFG_W'($urandom), CFG_W'($urandom));
				next_reconfig = accepted_requests + 150;
			end
			if ($urandom_range(99) < 15)
				stray_request();
			else
				host_session();
		end
	endtask

	task automatic test_stall_and_drain();
		// Hold the output off long enough for the block to back up onto its input.
		hold_request = 300;
		repeat (30) host_session();
		// The host then waits for every outstanding answer before carrying on.
		wait_for_drain();
		repeat (10) host_session();
	endtask

	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	always @(posedge clk) begin
		sector_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with no request waiting: status %0d offset %h address %h",
					$time, status, file_offset, table_address);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status || file_offset !== want.file_offset
						|| table_address !== want.table_address) begin
					$display("%0t: expected status %0d offset %h address %h", $time,
						want.status, want.file_offset, want.table_address);
					$display("%0t: actual   status %0d offset %h address %h", $time,
						status, file_offset, table_address);
					mismatches++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= tlst_pkg::REG_CLUSTER_BITS;
		cfg_data      <= '0;
		in_valid      <= 1'b0;
		operation     <= tlst_pkg::OP_WRITE_L1;
		entry_index   <= '0;
		entry_value   <= '0;
		sector_number <= '0;
		out_ready     <= 1'b0;
		foreach (table_pool[i])
			table_pool[i] = rand64();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_lookup();
		test_register_limits();
		test_random_traffic(500);
		sender_idle_pct   = 54;
		receiver_idle_pct = 7;
		test_random_traffic(500);
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		test_stall_and_drain();
		test_random_traffic(500);

		wait_for_drain();
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
